@@ rtl/core/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the differential drive odometry
// Holds fixed-point constants, the CORDIC arctangent table and the
// front-to-back queue entry type.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int CordicSteps = 24;
   localparam int IterW       = 5;

   localparam logic signed [31:0] TwoPiQ28  = 32'sd1686629713;
   localparam logic signed [31:0] PiQ28     = 32'sd843314857;
   localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
   localparam logic [31:0]        R2dQ24    = 32'd961263669;
   localparam logic signed [33:0] GainQ30   = 34'sd652032874;
   localparam logic signed [47:0] PosMax    = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] PosMin    = 48'sh8000_0000_0000;

   localparam logic [1:0] CSR_LEFT  = 2'd0;
   localparam logic [1:0] CSR_RIGHT = 2'd1;
   localparam logic [1:0] CSR_INVWB = 2'd2;

   // one queued transaction: wrapped heading and distance
   typedef struct packed {
      logic signed [31:0] heading;
      logic signed [56:0] distance;
   } work_type;

   localparam int QDepth = 2;

   function automatic logic [28:0] atan_q28(input logic [IterW-1:0] i);
      unique case (i)
         5'd0:  atan_q28 = 29'd210828714;
         5'd1:  atan_q28 = 29'd124459457;
         5'd2:  atan_q28 = 29'd65760959;
         5'd3:  atan_q28 = 29'd33381290;
         5'd4:  atan_q28 = 29'd16755422;
         5'd5:  atan_q28 = 29'd8385879;
         5'd6:  atan_q28 = 29'd4193963;
         5'd7:  atan_q28 = 29'd2097109;
         5'd8:  atan_q28 = 29'd1048571;
         5'd9:  atan_q28 = 29'd524287;
         5'd29: atan_q28 = 29'd0;
         default: atan_q28 = 29'd1 << (5'd28 - i);
      endcase
   endfunction

endpackage

@@ rtl/core/diff_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// diff_drive_odometry: dead-reckoning odometry for a differential drive
// Channel  Dir  Payload (low bits first)
// req      in   left_count[31:0], right_count[63:32]
// rsp      out  x_pos[47:0], y_pos[95:48], heading_deg[121:96]
// csr      in   index 0..2, 32-bit data
// The front runs one registered step per state (the heading-step multiply
// split over two of them); the back runs 24 CORDIC iterations on one shared
// adder pair. The back takes a new queue entry only after its last result
// has been loaded into the rsp register.
// Reset is synchronous; it clears counts, heading and position and sets the CSR registers to their defaults.
// A stalled rsp holds the result; the two-entry queue lets the front go on.
// ----------------------------------------------------------------------------
module diff_drive_odometry (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // left_count, right_count
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // x_pos, y_pos, heading_deg
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [31:0] left_ff, right_ff, invwb_ff;
   logic push, full, pop, not_empty;
   ddo_pkg::work_type push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 32'd16777216;
         right_ff <= 32'd16777216;
         invwb_ff <= 32'd167772;
      end else if (csr_we) begin
         priority case (csr_index)
            ddo_pkg::CSR_LEFT:  left_ff <= csr_wdata;
            ddo_pkg::CSR_RIGHT: right_ff <= csr_wdata;
            ddo_pkg::CSR_INVWB: invwb_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ddo_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .left_scale(left_ff), .right_scale(right_ff), .inv_wb(invwb_ff),
      .push, .push_data, .q_full(full)
   );

   ddo_queue u_queue (
      .clock, .reset, .push, .push_data, .full,
      .pop, .not_empty, .pop_data
   );

   ddo_back u_back (
      .clock, .reset, .q_valid(not_empty), .q_data(pop_data), .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

@@ rtl/core/ddo_front.sv @@
// ----------------------------------------------------------------------------
// ddo_front: input stage of the odometry
// Forms count deltas, wheel travel, distance and the wrapped heading over a
// short sequence of registered steps and pushes the result into the queue.
// ----------------------------------------------------------------------------
module ddo_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,
   input  logic [31:0]         left_scale,
   input  logic [31:0]         right_scale,
   input  logic [31:0]         inv_wb,
   output logic                push,
   output ddo_pkg::work_type   push_data,
   input  logic                q_full
);

   typedef enum logic [2:0] {
      S_IDLE, S_TRAVEL, S_SUM, S_MULLO, S_MULHI, S_HEAD, S_WRAP, S_PUSH
   } state_type;

   localparam logic signed [31:0] TwoPiQ = ddo_pkg::TwoPiQ28;
   localparam logic signed [33:0] TwoPi1 = 34'(TwoPiQ);
   localparam logic signed [33:0] TwoPi2 = TwoPi1 + TwoPi1;

   state_type state_ff;
   logic [31:0] prev_l_ff, prev_r_ff;
   logic signed [31:0] heading_ff;
   logic [32:0] mag_l_ff, mag_r_ff;
   logic neg_l_ff, neg_r_ff;
   logic signed [56:0] lcm_ff, rcm_ff;
   logic signed [56:0] dist_ff;
   logic [56:0] dmag_ff;
   logic dneg_ff;
   logic [63:0] plo_ff;
   logic [56:0] phi_ff;
   logic signed [32:0] hsum_ff;

   logic [31:0] dl, dr;
   logic [64:0] pl, pr;
   logic signed [57:0] diff, sum;
   logic [63:0] plo_in;
   logic [56:0] phi_in;
   logic [31:0] stepm;
   logic signed [32:0] inc, hs;
   logic signed [32:0] wrapped;

   assign dl = req_tdata[31:0] - prev_l_ff;
   assign dr = req_tdata[63:32] - prev_r_ff;
   assign pl = {32'd0, mag_l_ff} * {33'd0, left_scale};
   assign pr = {32'd0, mag_r_ff} * {33'd0, right_scale};
   assign sum  = 58'(lcm_ff) + 58'(rcm_ff);
   assign diff = 58'(lcm_ff) - 58'(rcm_ff);
   assign plo_in = {32'd0, dmag_ff[31:0]} * {32'd0, inv_wb};
   assign phi_in = {32'd0, dmag_ff[56:32]} * {25'd0, inv_wb};

   always_comb begin
      // (hi<<20)+(lo>>12) with saturation at 2^31-1
      logic [52:0] tot;
      tot = 53'(plo_ff >> 12) + (53'(phi_ff) << 20);
      if (phi_ff >= 57'd2048 || tot > 53'h7FFF_FFFF) stepm = 32'h7FFF_FFFF;
      else stepm = tot[31:0];
   end
   assign inc = dneg_ff ? -$signed({1'b0, stepm}) : $signed({1'b0, stepm});
   assign hs  = 33'(heading_ff) + inc;
   always_comb begin
      // truncating remainder; |hs| < 3 * two pi, so pick one of five offsets
      logic signed [33:0] t;
      t = 34'(hsum_ff);
      priority if (t >= TwoPi2) wrapped = 33'(t - TwoPi2);
      else if (t >= TwoPi1) wrapped = 33'(t - TwoPi1);
      else if (t <= -TwoPi2) wrapped = 33'(t + TwoPi2);
      else if (t <= -TwoPi1) wrapped = 33'(t + TwoPi1);
      else wrapped = t[32:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign push = (state_ff == S_PUSH) && !q_full;
   assign push_data.heading = heading_ff;
   assign push_data.distance = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         heading_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               prev_l_ff <= req_tdata[31:0];
               prev_r_ff <= req_tdata[63:32];
               neg_l_ff <= dl[31];
               neg_r_ff <= dr[31];
               mag_l_ff <= dl[31] ? 33'(-{1'b1, dl}) : {1'b0, dl};
               mag_r_ff <= dr[31] ? 33'(-{1'b1, dr}) : {1'b0, dr};
               state_ff <= S_TRAVEL;
            end
            S_TRAVEL: begin
               lcm_ff <= neg_l_ff ? -$signed({1'b0, pl[63:8]}) : $signed({1'b0, pl[63:8]});
               rcm_ff <= neg_r_ff ? -$signed({1'b0, pr[63:8]}) : $signed({1'b0, pr[63:8]});
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // truncate toward zero: add one before the shift when negative
               dist_ff <= 57'((sum + 58'(sum[57])) >>> 1);
               dneg_ff <= diff[57];
               dmag_ff <= diff[57] ? 57'(-diff) : 57'(diff);
               state_ff <= S_MULLO;
            end
            S_MULLO: begin
               plo_ff <= plo_in;
               state_ff <= S_MULHI;
            end
            S_MULHI: begin
               phi_ff <= phi_in;
               state_ff <= S_HEAD;
            end
            S_HEAD: begin
               hsum_ff <= hs;
               state_ff <= S_WRAP;
            end
            S_WRAP: begin
               heading_ff <= wrapped[31:0];
               state_ff <= S_PUSH;
            end
            S_PUSH: if (!q_full) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> state_ff == S_PUSH) else $error("push outside push state");
   assert property (@(posedge clock) disable iff (reset)
      (heading_ff < TwoPiQ) && (heading_ff > -TwoPiQ)) else $error("heading not wrapped");
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == S_TRAVEL) else $error("accept lost");

endmodule

@@ rtl/core/ddo_queue.sv @@
// ----------------------------------------------------------------------------
// ddo_queue: short queue between front and back
// Two entries of work, pushed by the front and popped by the back.
// ----------------------------------------------------------------------------
module ddo_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ddo_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ddo_pkg::work_type pop_data
);

   ddo_pkg::work_type mem_ff [ddo_pkg::QDepth];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty)) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count overflow");

endmodule

@@ rtl/core/ddo_back.sv @@
// ----------------------------------------------------------------------------
// ddo_back: position update of the odometry
// Iterative CORDIC for sin and cos, then distance products, saturating
// accumulation of x and y, degree conversion and the output register.
// ----------------------------------------------------------------------------
module ddo_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  ddo_pkg::work_type  q_data,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [127:0]       rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_FOLD, S_ITER, S_MLO, S_MHI, S_ACC, S_OUT
   } state_type;

   state_type state_ff;
   logic signed [31:0] h_ff;
   logic signed [56:0] dist_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [31:0] z_ff;
   logic flip_ff;
   logic [ddo_pkg::IterW-1:0] it_ff;
   logic [56:0] dmag_ff;
   logic [33:0] smag_ff, cmag_ff;
   logic sneg_ff, cneg_ff;
   logic [74:0] sp_ff, cp_ff;
   logic [55:0] shi_ff, chi_ff;
   logic signed [47:0] px_ff, py_ff;
   logic signed [25:0] deg_ff;
   logic [63:0] degp_ff;
   logic rv_ff;
   logic [47:0] ox_ff, oy_ff;
   logic [25:0] od_ff;

   logic signed [33:0] a1, a2, xs, ys, sv, cv;
   logic signed [58:0] nx, ny;
   logic [74:0] slo, clo;

   localparam logic signed [33:0] Tp = 34'(ddo_pkg::TwoPiQ28);
   localparam logic signed [33:0] Pp = 34'(ddo_pkg::PiQ28);
   localparam logic signed [33:0] Hp = 34'(ddo_pkg::HalfPiQ28);

   assign a1 = (34'(h_ff) > Pp) ? 34'(h_ff) - Tp :
               (34'(h_ff) < -Pp) ? 34'(h_ff) + Tp : 34'(h_ff);
   assign a2 = (a1 > Hp) ? a1 - Pp : (a1 < -Hp) ? a1 + Pp : a1;
   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign sv = flip_ff ? -y_ff : y_ff;
   assign cv = flip_ff ? -x_ff : x_ff;
   assign slo = 75'({32'd0, dmag_ff[31:0]} * {30'd0, smag_ff});
   assign clo = 75'({32'd0, dmag_ff[31:0]} * {30'd0, cmag_ff});
   always_comb begin
      logic [57:0] sm, cm;
      sm = 58'(sp_ff >> 30) + {shi_ff, 2'b00};
      cm = 58'(cp_ff >> 30) + {chi_ff, 2'b00};
      nx = 59'(px_ff) + (sneg_ff ? -$signed({1'b0, sm}) : $signed({1'b0, sm}));
      ny = 59'(py_ff) + (cneg_ff ? -$signed({1'b0, cm}) : $signed({1'b0, cm}));
   end

   assign pop = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {6'd0, od_ff, oy_ff, ox_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         px_ff <= '0;
         py_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         // drop valid once taken, unless a new result replaces it
         if (rv_ff && rsp_tready && (state_ff != S_OUT)) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               h_ff <= q_data.heading;
               dist_ff <= q_data.distance;
               state_ff <= S_FOLD;
            end
            S_FOLD: begin
               flip_ff <= (a1 > Hp) || (a1 < -Hp);
               z_ff <= a2[31:0];
               x_ff <= ddo_pkg::GainQ30;
               y_ff <= '0;
               it_ff <= '0;
               dmag_ff <= dist_ff[56] ? 57'(-dist_ff) : 57'(dist_ff);
               degp_ff <= {32'd0, (h_ff[31] ? 32'(-h_ff) : 32'(h_ff))} *
                          {32'd0, ddo_pkg::R2dQ24};
               state_ff <= S_ITER;
            end
            S_ITER: begin
               if (!z_ff[31]) begin
                  x_ff <= x_ff - ys; y_ff <= y_ff + xs;
                  z_ff <= z_ff - 32'(ddo_pkg::atan_q28(it_ff));
               end else begin
                  x_ff <= x_ff + ys; y_ff <= y_ff - xs;
                  z_ff <= z_ff + 32'(ddo_pkg::atan_q28(it_ff));
               end
               it_ff <= it_ff + 1'b1;
               if (it_ff == ddo_pkg::IterW'(ddo_pkg::CordicSteps - 1)) state_ff <= S_MLO;
            end
            S_MLO: begin
               sneg_ff <= dist_ff[56] != sv[33];
               cneg_ff <= dist_ff[56] != cv[33];
               smag_ff <= sv[33] ? 34'(-sv) : 34'(sv);
               cmag_ff <= cv[33] ? 34'(-cv) : 34'(cv);
               deg_ff <= h_ff[31] ? -$signed({1'b0, degp_ff[60:36]}) :
                                     $signed({1'b0, degp_ff[60:36]});
               state_ff <= S_MHI;
            end
            S_MHI: begin
               sp_ff <= slo;
               cp_ff <= clo;
               shi_ff <= 56'({32'd0, dmag_ff[56:32]} * {23'd0, smag_ff});
               chi_ff <= 56'({32'd0, dmag_ff[56:32]} * {23'd0, cmag_ff});
               state_ff <= S_ACC;
            end
            S_ACC: begin
               px_ff <= (nx > 59'(ddo_pkg::PosMax)) ? ddo_pkg::PosMax :
                        (nx < 59'(ddo_pkg::PosMin)) ? ddo_pkg::PosMin : nx[47:0];
               py_ff <= (ny > 59'(ddo_pkg::PosMax)) ? ddo_pkg::PosMax :
                        (ny < 59'(ddo_pkg::PosMin)) ? ddo_pkg::PosMin : ny[47:0];
               state_ff <= S_OUT;
            end
            S_OUT: if (!rv_ff || rsp_tready) begin
               ox_ff <= px_ff;
               oy_ff <= py_ff;
               od_ff <= deg_ff;
               rv_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == S_FOLD) else $error("pop not taken");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER) |-> it_ff < ddo_pkg::IterW'(ddo_pkg::CordicSteps))
      else $error("iteration count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rv_ff || rsp_tready)) |=> rv_ff) else $error("result lost");

endmodule

@@ tb/diff_drive_odometry_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_tb: self-checking bench for the odometry block
// Drives encoder count pairs over req, predicts x, y and heading per
// transaction with a bit-exact fixed-point model and checks every rsp
// transaction in order. Covers register extremes, rollover, heading step
// saturation, position clamping and random idling on both sides.
// ----------------------------------------------------------------------------
module diff_drive_odometry_tb;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam longint     StepMax    = 64'd2147483647;

   localparam longint ArctanQ28 [30] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2,
      1, 0};

   typedef struct {
      logic [47:0] x_pos;
      logic [47:0] y_pos;
      logic [25:0] heading_deg;
   } pose_type;

   class odo_scoreboard;
      logic [31:0]       left_scale, right_scale, inv_base;
      logic [31:0]       last_left, last_right;
      longint            heading, pos_x, pos_y;
      pose_type          pose_q[$];
      int                errors;

      function new();
         left_scale = 32'd16777216;
         right_scale = 32'd16777216;
         inv_base = 32'd167772;
         last_left = '0;
         last_right = '0;
         heading = 0;
         pos_x = 0;
         pos_y = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            ddo_pkg::CSR_LEFT:  left_scale = val;
            ddo_pkg::CSR_RIGHT: right_scale = val;
            ddo_pkg::CSR_INVWB: inv_base = val;
            default: ;
         endcase
      endfunction

      function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      function longint signed_of(longint unsigned m, bit neg);
         return neg ? -longint'(m) : longint'(m);
      endfunction

      function longint travel(logic [31:0] now, logic [31:0] was, logic [31:0] scale);
         logic signed [31:0] d;
         longint             dl;
         d = now - was;
         dl = d;
         return signed_of((magnitude(dl) * longint'({32'd0, scale})) >> 8, dl < 0);
      endfunction

      function longint clamp48(longint v);
         if (v > 64'sd140737488355327) return 64'sd140737488355327;
         if (v < -64'sd140737488355328) return -64'sd140737488355328;
         return v;
      endfunction

      function longint scaled_trig(longint distance, longint trig);
         longint unsigned m, b, hi, lo;
         m = magnitude(distance);
         b = magnitude(trig);
         hi = (m >> 32) * b;
         lo = (m & 64'hFFFF_FFFF) * b;
         return signed_of((hi << 2) + (lo >> 30), (distance < 0) != (trig < 0));
      endfunction

      function void note_input(logic [31:0] left, logic [31:0] right);
         longint            lcm, rcm, distance, diff, inc, h, deg, a, cx, cy, z, xs, ys;
         longint unsigned   m, hi, lo;
         bit                big, flip;
         pose_type          p;
         lcm = travel(left, last_left, left_scale);
         rcm = travel(right, last_right, right_scale);
         last_left = left;
         last_right = right;
         distance = (lcm + rcm) / 2;
         diff = lcm - rcm;
         // heading step, saturated to the 32-bit Q28 range
         m = magnitude(diff);
         hi = (m >> 32) * inv_base;
         lo = (m & 64'hFFFF_FFFF) * inv_base;
         big = hi >= 64'd2048;
         m = big ? StepMax : (hi << 20) + (lo >> 12);
         if (m > StepMax) m = StepMax;
         inc = signed_of(m, diff < 0);
         h = (heading + inc) % longint'(ddo_pkg::TwoPiQ28);
         heading = h;
         deg = signed_of((magnitude(h) * longint'(ddo_pkg::R2dQ24)) >> 36, h < 0);
         // fold into +-pi/2, then rotate
         a = h;
         flip = 0;
         if (a > ddo_pkg::PiQ28) a -= ddo_pkg::TwoPiQ28;
         if (a < -longint'(ddo_pkg::PiQ28)) a += ddo_pkg::TwoPiQ28;
         if (a > ddo_pkg::HalfPiQ28) begin
            a -= ddo_pkg::PiQ28;
            flip = 1;
         end else if (a < -longint'(ddo_pkg::HalfPiQ28)) begin
            a += ddo_pkg::PiQ28;
            flip = 1;
         end
         cx = ddo_pkg::GainQ30;
         cy = 0;
         z = a;
         for (int i = 0; i < ddo_pkg::CordicSteps; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0) begin
               cx -= ys; cy += xs; z -= ArctanQ28[i];
            end else begin
               cx += ys; cy -= xs; z += ArctanQ28[i];
            end
         end
         if (flip) begin
            cx = -cx;
            cy = -cy;
         end
         pos_x = clamp48(pos_x + scaled_trig(distance, cy));
         pos_y = clamp48(pos_y + scaled_trig(distance, cx));
         p.x_pos = pos_x[47:0];
         p.y_pos = pos_y[47:0];
         p.heading_deg = deg[25:0];
         pose_q.push_back(p);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check(logic [127:0] data);
         pose_type e;
         if (pose_q.size() == 0) begin
            report($sformatf("unexpected result %h", data));
            return;
         end
         e = pose_q.pop_front();
         if (data[47:0] !== e.x_pos)
            report($sformatf("x_pos got %h want %h", data[47:0], e.x_pos));
         if (data[95:48] !== e.y_pos)
            report($sformatf("y_pos got %h want %h", data[95:48], e.y_pos));
         if (data[121:96] !== e.heading_deg)
            report($sformatf("heading_deg got %h want %h", data[121:96], e.heading_deg));
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;    // left_count, right_count
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;         // x_pos, y_pos, heading_deg
   logic         csr_we = 0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   odo_scoreboard pose_book = new();
   int            send_idle_pct = 15;
   int            recv_idle_pct = 64;
   int            hold_request = 0;
   int            hold_left = 0;
   int            sent = 0;
   logic [31:0]   cur_left = '0, cur_right = '0;

   diff_drive_odometry uut (.*);

   always #5 clock = ~clock;

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left <= hold_request;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) pose_book.check(rsp_tdata);

   task automatic send_counts(logic [31:0] left, logic [31:0] right);
      if (sent == 220) begin
         send_idle_pct = 64; recv_idle_pct = 15;
      end else if (sent == 440) begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {right, left};
      do @(posedge clock); while (!req_tready);
      pose_book.note_input(left, right);
      cur_left = left;
      cur_right = right;
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pose_book.pose_q.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      pose_book.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drive_random(int n);
      logic [31:0] l, r;
      int          turn;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 75) begin
            // plausible motion: small forward travel with some turning
            turn = $urandom_range(60) - 30;
            l = cur_left + $urandom_range(300) - 100 + turn;
            r = cur_right + $urandom_range(300) - 100 - turn;
         end else begin
            l = $urandom;
            r = $urandom;
         end
         send_counts(l, r);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values
      send_counts(32'd0, 32'd0);
      send_counts(32'd100, 32'd100);
      send_counts(32'd250, 32'd150);
      send_counts(32'd150, 32'd250);
      send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_counts(32'h8000_0000, 32'h8000_0000);   // counter rollover
      send_counts(32'h7FFF_FFFF, 32'h8000_0000);   // single-count heading step
      send_counts(32'h8000_0000, 32'h7FFF_FFFF);
      send_counts(32'hFFFF_FFFF, 32'h0000_0000);
      send_counts(32'h0000_0000, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++) send_counts(cur_left + 4000, cur_right - 4000);

      // long receiver hold-off while the sender keeps offering
      hold_request = 400;
      drive_random(120);
      drain();

      write_csr(ddo_pkg::CSR_LEFT, 32'hFFFF_FFFF);
      write_csr(ddo_pkg::CSR_RIGHT, 32'hFFFF_FFFF);
      write_csr(ddo_pkg::CSR_INVWB, 32'hFFFF_FFFF);
      // drive both wheels by the full half range to clamp the position
      for (int i = 0; i < 8; i++) begin
         send_counts(cur_left ^ 32'h8000_0000, cur_right ^ 32'h8000_0000);
      end
      drive_random(90);
      drain();

      write_csr(ddo_pkg::CSR_LEFT, 32'd0);
      write_csr(ddo_pkg::CSR_RIGHT, 32'd0);
      write_csr(ddo_pkg::CSR_INVWB, 32'd0);
      drive_random(60);
      drain();

      write_csr(ddo_pkg::CSR_LEFT, $urandom);
      write_csr(ddo_pkg::CSR_RIGHT, $urandom_range(32'h0400_0000));
      write_csr(ddo_pkg::CSR_INVWB, $urandom);
      write_csr(CSR_UNUSED, $urandom);
      drive_random(130);
      // pause until every result has come back
      drain();
      drive_random(110);
      drain();

      write_csr(ddo_pkg::CSR_LEFT, $urandom_range(32'h0200_0000, 32'h0080_0000));
      write_csr(ddo_pkg::CSR_RIGHT, $urandom_range(32'h0200_0000, 32'h0080_0000));
      write_csr(ddo_pkg::CSR_INVWB, $urandom_range(32'h0010_0000));
      drive_random(110);
      drain();

      if (pose_book.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
